/* hw/rtl/mp3_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mp3_pkg
// Shared constants, types and the fp32 maximum function for the 3x3 pooler.
// ----------------------------------------------------------------------------
package mp3_pkg;

  // Channel lanes carried by one pixel and the width of one fp32 value.
  localparam int LANES  = 4;
  localparam int LANE_W = 32;

  // Configuration port geometry.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_PADDED_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PADDED_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_WIDTH     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_HEIGHT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_TWO    = 3'd4;

  localparam logic [LANE_W-1:0] CANON_NAN = 32'h7FC0_0000;

  // Per-lane pipeline enables driven by the top level.
  typedef struct packed {
    logic load_in;   // input transfer, capture the new pixel
    logic adv1;      // stage 1 moves: column maximum is registered
    logic adv2;      // stage 2 moves: column history shifts
    logic load_out;  // window maximum goes to the output register
  } lane_ctl_t;

  function automatic logic is_nan(input logic [LANE_W-1:0] x);
    is_nan = (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
  endfunction

  // Monotonic key: larger key means larger float, -0 below +0.
  function automatic logic [LANE_W-1:0] order_key(input logic [LANE_W-1:0] x);
    order_key = x[31] ? ~x : (x | 32'h8000_0000);
  endfunction

  // Maximum with the RISC-V fmax rule for NaN operands.
  function automatic logic [LANE_W-1:0] fmax(input logic [LANE_W-1:0] a,
                                             input logic [LANE_W-1:0] b);
    logic na;
    logic nb;
    na = is_nan(a);
    nb = is_nan(b);
    if (na && nb) begin
      fmax = CANON_NAN;
    end else if (na) begin
      fmax = b;
    end else if (nb) begin
      fmax = a;
    end else begin
      fmax = (order_key(a) >= order_key(b)) ? a : b;
    end
  endfunction

endpackage

/* hw/rtl/mp3_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mp3_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mp3_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/mp3_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mp3_ctrl
// Configuration registers, raster position counters and window decision.
// ----------------------------------------------------------------------------
module mp3_ctrl #(
  parameter int MAX_ROW_WIDTH = 1024
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_write_en,
  input  logic [mp3_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mp3_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             accept,
  output logic [$clog2(MAX_ROW_WIDTH)-1:0] addr,
  output logic                             emit,
  output logic                             done
);

  localparam int AW = $clog2(MAX_ROW_WIDTH);
  localparam logic [15:0] MAXW = 16'(MAX_ROW_WIDTH);

  logic [10:0]   pw_r;
  logic [15:0]   ph_r;
  logic [9:0]    ow_r;
  logic [15:0]   oh_r;
  logic          s2_r;
  logic [AW-1:0] col_r;
  logic [AW-1:0] col_nxt;
  logic [15:0]   row_r;
  logic [15:0]   row_nxt;

  logic [15:0] w_eff;
  logic [15:0] h_eff;
  logic [15:0] fit_w;
  logic [15:0] fit_h;
  logic [15:0] ow_lim;
  logic [15:0] oh_lim;
  logic [15:0] c0;
  logic [15:0] r0;
  logic [15:0] c1;
  logic [15:0] r1;
  logic [15:0] ox;
  logic [15:0] oy;
  logic [15:0] dc;
  logic [15:0] dr;
  logic        on_grid;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pw_r <= 11'd3;
      ph_r <= 16'd3;
      ow_r <= 10'd1;
      oh_r <= 16'd1;
      s2_r <= 1'b0;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        mp3_pkg::CFG_PADDED_WIDTH:  pw_r <= cfg_data[10:0];
        mp3_pkg::CFG_PADDED_HEIGHT: ph_r <= cfg_data;
        mp3_pkg::CFG_OUT_WIDTH:     ow_r <= cfg_data[9:0];
        mp3_pkg::CFG_OUT_HEIGHT:    oh_r <= cfg_data;
        mp3_pkg::CFG_STRIDE_TWO:    s2_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Effective image size and output limits.
  always_comb begin
    if (pw_r < 11'd3) begin
      w_eff = 16'd3;
    end else if ({5'd0, pw_r} > MAXW) begin
      w_eff = MAXW;
    end else begin
      w_eff = {5'd0, pw_r};
    end
    h_eff  = (ph_r < 16'd3) ? 16'd3 : ph_r;
    fit_w  = ((w_eff - 16'd3) >> s2_r) + 16'd1;
    fit_h  = ((h_eff - 16'd3) >> s2_r) + 16'd1;
    ow_lim = ({6'd0, ow_r} < fit_w) ? {6'd0, ow_r} : fit_w;
    oh_lim = (oh_r < fit_h) ? oh_r : fit_h;
  end

  // Position of the current pixel, corrected for a shrunk size.
  always_comb begin
    c0 = 16'(col_r);
    r0 = row_r;
    if (c0 >= w_eff) begin
      c0 = 16'd0;
      r0 = row_r + 16'd1;
    end
    if (r0 >= h_eff) begin
      r0 = 16'd0;
    end
    dr      = r0 - 16'd2;
    dc      = c0 - 16'd2;
    oy      = dr >> s2_r;
    ox      = dc >> s2_r;
    on_grid = !s2_r || ((dr[0] | dc[0]) == 1'b0);
    emit    = (r0 >= 16'd2) && (c0 >= 16'd2) && on_grid &&
              (oy < oh_lim) && (ox < ow_lim);
    done    = (oy == oh_lim - 16'd1) && (ox == ow_lim - 16'd1);
    addr    = c0[AW-1:0];
  end

  // Next raster position.
  always_comb begin
    c1      = c0 + 16'd1;
    r1      = r0 + 16'd1;
    col_nxt = c1[AW-1:0];
    row_nxt = r0;
    if (c1 >= w_eff) begin
      col_nxt = '0;
      row_nxt = (r1 >= h_eff) ? 16'd0 : r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

/* hw/rtl/mp3_lane.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mp3_lane
// One channel lane: column maximum, two-column history and window maximum.
// ----------------------------------------------------------------------------
module mp3_lane (
  input  logic                          clk,
  input  mp3_pkg::lane_ctl_t            ctl,
  input  logic [mp3_pkg::LANE_W-1:0]    cur_in,
  input  logic [mp3_pkg::LANE_W-1:0]    upper,
  input  logic [mp3_pkg::LANE_W-1:0]    middle,
  output logic [mp3_pkg::LANE_W-1:0]    cur1,
  output logic [mp3_pkg::LANE_W-1:0]    max_out
);

  logic [mp3_pkg::LANE_W-1:0] cur1_r;
  logic [mp3_pkg::LANE_W-1:0] colmax_r;
  logic [mp3_pkg::LANE_W-1:0] colmax_nxt;
  logic [mp3_pkg::LANE_W-1:0] hist0_r;
  logic [mp3_pkg::LANE_W-1:0] hist1_r;
  logic [mp3_pkg::LANE_W-1:0] max_r;
  logic [mp3_pkg::LANE_W-1:0] max_nxt;

  // Vertical maximum over the three rows of this column.
  assign colmax_nxt = mp3_pkg::fmax(mp3_pkg::fmax(upper, middle), cur1_r);
  // Horizontal maximum over this and the two previous columns.
  assign max_nxt    = mp3_pkg::fmax(mp3_pkg::fmax(colmax_r, hist0_r), hist1_r);

  always_ff @(posedge clk) begin
    if (ctl.load_in) begin
      cur1_r <= cur_in;
    end
    if (ctl.adv1) begin
      colmax_r <= colmax_nxt;
    end
    if (ctl.adv2) begin
      hist0_r <= colmax_r;
      hist1_r <= hist0_r;
    end
    if (ctl.load_out) begin
      max_r <= max_nxt;
    end
  end

  assign cur1    = cur1_r;
  assign max_out = max_r;

endmodule

/* hw/rtl/max_pool_3x3_stream.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_pool_3x3_stream
// Streaming 3x3 max pooling, stride 1 or 2, over a padded fp32 image.
// ----------------------------------------------------------------------------
// Usage: pixels of an already padded image enter in raster order on the
// in_ channel, one pixel per transfer, four fp32 channel lanes each. When a
// pixel closes a 3x3 window on the stride grid inside the configured output
// size, one result leaves on the out_ channel with the lane-wise maximum;
// out_image_done marks the last result of an image. Positions wrap to row 0
// after the last padded row, so images follow each other without a gap.
// Throughput is one pixel per cycle while no result waits on out_stall; each
// line store has one read port and one write port, and each pixel reads its
// column once and rewrites it when it advances out of stage 1.
// From input transfer to out_valid a pixel passes the RAM read register, the
// column maximum register and the window maximum register. Reset clears the
// position counters, pipeline valids and the configuration to a 3x3 image
// with one output. The line stores need no clearing pass. While out_stall
// holds a waiting result, the whole pipeline holds and in_stall is raised;
// otherwise inputs are taken every cycle. The user must write configuration
// through cfg_ only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module max_pool_3x3_stream #(
  parameter int MAX_ROW_WIDTH = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_write_en,
  input  logic [mp3_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mp3_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [31:0]                    in_lane0_value,
  input  logic [31:0]                    in_lane1_value,
  input  logic [31:0]                    in_lane2_value,
  input  logic [31:0]                    in_lane3_value,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [31:0]                    out_lane0_max,
  output logic [31:0]                    out_lane1_max,
  output logic [31:0]                    out_lane2_max,
  output logic [31:0]                    out_lane3_max,
  output logic                           out_image_done
);

  localparam int AW = $clog2(MAX_ROW_WIDTH);
  localparam int VW = mp3_pkg::LANES * mp3_pkg::LANE_W;

  logic          en;
  logic          accept;
  logic [AW-1:0] addr0;
  logic          emit0;
  logic          done0;

  logic          v1_r;
  logic          emit1_r;
  logic          done1_r;
  logic [AW-1:0] addr1_r;
  logic          v2_r;
  logic          emit2_r;
  logic          done2_r;
  logic          out_valid_r;
  logic          done_r;

  logic [VW-1:0] in_vec;
  logic [VW-1:0] upper_rd;
  logic [VW-1:0] middle_rd;
  logic [VW-1:0] cur1_vec;
  logic [VW-1:0] max_vec;
  logic          ram_we;

  mp3_pkg::lane_ctl_t lane_ctl;

  // Global pipeline advance: hold everything while a result waits.
  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;
  assign accept   = in_valid && en;
  assign ram_we   = en && v1_r;

  assign in_vec = {in_lane3_value, in_lane2_value, in_lane1_value, in_lane0_value};

  mp3_ctrl #(
    .MAX_ROW_WIDTH(MAX_ROW_WIDTH)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .accept       (accept),
    .addr         (addr0),
    .emit         (emit0),
    .done         (done0)
  );

  // Row two above: receives the old middle row on write-back.
  mp3_ram #(
    .WIDTH(VW),
    .DEPTH(MAX_ROW_WIDTH)
  ) u_upper (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr1_r),
    .wdata (middle_rd),
    .re    (accept),
    .raddr (addr0),
    .rdata (upper_rd)
  );

  // Row directly above: receives the current pixel on write-back.
  mp3_ram #(
    .WIDTH(VW),
    .DEPTH(MAX_ROW_WIDTH)
  ) u_middle (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr1_r),
    .wdata (cur1_vec),
    .re    (accept),
    .raddr (addr0),
    .rdata (middle_rd)
  );

  always_comb begin
    lane_ctl.load_in  = accept;
    lane_ctl.adv1     = en && v1_r;
    lane_ctl.adv2     = en && v2_r;
    lane_ctl.load_out = en && v2_r && emit2_r;
  end

  // Lanes working side by side.
  for (genvar k = 0; k < mp3_pkg::LANES; k++) begin : g_lane
    mp3_lane u_lane (
      .clk     (clk),
      .ctl     (lane_ctl),
      .cur_in  (in_vec[k*mp3_pkg::LANE_W +: mp3_pkg::LANE_W]),
      .upper   (upper_rd[k*mp3_pkg::LANE_W +: mp3_pkg::LANE_W]),
      .middle  (middle_rd[k*mp3_pkg::LANE_W +: mp3_pkg::LANE_W]),
      .cur1    (cur1_vec[k*mp3_pkg::LANE_W +: mp3_pkg::LANE_W]),
      .max_out (max_vec[k*mp3_pkg::LANE_W +: mp3_pkg::LANE_W])
    );
  end

  // Pipeline control: valids and window flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r        <= accept;
      v2_r        <= v1_r;
      out_valid_r <= v2_r && emit2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      emit1_r <= emit0;
      done1_r <= done0;
      addr1_r <= addr0;
      emit2_r <= emit1_r;
      done2_r <= done1_r;
      done_r  <= done2_r;
    end
  end

  // Result merge onto the output ports.
  assign out_valid      = out_valid_r;
  assign out_image_done = done_r;
  assign out_lane0_max  = max_vec[0*mp3_pkg::LANE_W +: mp3_pkg::LANE_W];
  assign out_lane1_max  = max_vec[1*mp3_pkg::LANE_W +: mp3_pkg::LANE_W];
  assign out_lane2_max  = max_vec[2*mp3_pkg::LANE_W +: mp3_pkg::LANE_W];
  assign out_lane3_max  = max_vec[3*mp3_pkg::LANE_W +: mp3_pkg::LANE_W];

  // The input side is only held back by a waiting result.
  a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid_r && out_stall))
    else $error("input stalled without a waiting result");

  // Write-back never hits the column being read in the same cycle.
  a_ram_port : assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && accept) |-> (addr1_r != addr0))
    else $error("line store read and write collide");

  // A window leaving stage 2 appears as a result next cycle.
  a_emit : assert property (@(posedge clk) disable iff (!rst_n)
    (en && v2_r && emit2_r) |=> out_valid_r)
    else $error("window result lost");

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the streaming 3x3 max pooler. A local model of the
// line stores, column history and position counters predicts every window
// maximum; results are compared lane by lane in order of arrival. Directed
// images cover the fmax NaN and signed-zero rules, then random phases sweep
// sizes, strides and output limits under random idling on both channels.
// ----------------------------------------------------------------------------
module testbench;

  typedef logic [mp3_pkg::LANES-1:0][31:0] pixel_t;

  typedef struct packed {
    pixel_t window_max;
    logic   last;
  } pool_result_t;

  // One row of the directed table: the pixel and, where it is plain, the
  // result that it must produce.
  typedef struct {
    pixel_t px;
    bit     typed;
    pixel_t want;
    bit     want_last;
  } directed_row_t;

  logic         clk;
  logic         rst_n;
  logic         cfg_write_en;
  logic [2:0]   cfg_index;
  logic [15:0]  cfg_data;
  logic         in_valid;
  logic         in_stall;
  pixel_t       in_px;
  logic         out_valid;
  logic         out_stall;
  logic [31:0]  out_m0, out_m1, out_m2, out_m3;
  logic         out_image_done;

  max_pool_3x3_stream dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_write_en(cfg_write_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_lane0_value(in_px[0]), .in_lane1_value(in_px[1]),
    .in_lane2_value(in_px[2]), .in_lane3_value(in_px[3]),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_lane0_max(out_m0), .out_lane1_max(out_m1),
    .out_lane2_max(out_m2), .out_lane3_max(out_m3),
    .out_image_done(out_image_done)
  );

  // Local copy of the pooler state and configuration.
  pixel_t        upper_rows [1024];
  pixel_t        middle_rows [1024];
  pixel_t        col_hist [2];
  int unsigned   row_pos, col_pos;
  int unsigned   reg_width, reg_height, reg_out_w, reg_out_h, reg_stride;

  pool_result_t  pending_max [$];
  int            errors;
  int            pixels_sent;
  bit            quiet;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // fmax with the RISC-V NaN rule; -0 ranks below +0.
  function automatic logic [31:0] fp_larger(logic [31:0] a, logic [31:0] b);
    bit a_nan, b_nan;
    logic [31:0] ka, kb;
    a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 0);
    b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 0);
    ka = a[31] ? ~a : {1'b1, a[30:0]};
    kb = b[31] ? ~b : {1'b1, b[30:0]};
    if (a_nan && b_nan) return mp3_pkg::CANON_NAN;
    if (a_nan) return b;
    if (b_nan) return a;
    return (ka >= kb) ? a : b;
  endfunction

  // Advance the local pooler by one accepted pixel; a closed window that lies
  // inside the output size gives one expected result.
  function automatic void pool_pixel(pixel_t px, output bit got, output pool_result_t res);
    int unsigned w, h, s, ow, oh, r, c, oy, ox;
    pixel_t colmax;
    w = reg_width < 3 ? 3 : (reg_width > 1024 ? 1024 : reg_width);
    h = reg_height < 3 ? 3 : reg_height;
    s = reg_stride;
    ow = ((w - 3) >> s) + 1;
    oh = ((h - 3) >> s) + 1;
    if (reg_out_w < ow) ow = reg_out_w;
    if (reg_out_h < oh) oh = reg_out_h;
    got = 1'b0;
    res = '0;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = (row_pos + 1) & 16'hFFFF;
    end
    if (row_pos >= h) row_pos = 0;
    r = row_pos;
    c = col_pos;
    for (int k = 0; k < mp3_pkg::LANES; k++)
      colmax[k] = fp_larger(fp_larger(upper_rows[c][k], middle_rows[c][k]), px[k]);
    upper_rows[c] = middle_rows[c];
    middle_rows[c] = px;
    if (r >= 2 && c >= 2) begin
      oy = (r - 2) >> s;
      ox = (c - 2) >> s;
      if ((s == 0 || (((r - 2) | (c - 2)) & 1) == 0) && oy < oh && ox < ow) begin
        for (int k = 0; k < mp3_pkg::LANES; k++)
          res.window_max[k] = fp_larger(fp_larger(colmax[k], col_hist[0][k]), col_hist[1][k]);
        res.last = (oy == oh - 1) && (ox == ow - 1);
        got = 1'b1;
      end
    end
    col_hist[1] = col_hist[0];
    col_hist[0] = colmax;
    col_pos = c + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = r + 1;
      if (row_pos >= h) row_pos = 0;
    end
  endfunction

  // Drive one pixel and hold it until the transfer; the in_stall seen at the
  // falling edge is the value at the next rising edge.
  task automatic send_pixel(pixel_t px, bit typed = 0, pixel_t want = '0, bit want_last = 0);
    bit got;
    pool_result_t res;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_px    <= px;
    @(negedge clk);
    while (in_stall) begin
      @(posedge clk);
      @(negedge clk);
    end
    pool_pixel(px, got, res);
    if (typed) begin
      res.window_max = want;
      res.last = want_last;
    end
    if (got) pending_max.push_back(res);
    pixels_sent++;
    @(posedge clk);
  endtask

  // Let every result drain, plus the pipeline depth for pixels without one.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_max.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_config(int unsigned w, int unsigned h, int unsigned ow,
                            int unsigned oh, int unsigned s);
    logic [2:0]  idx [5];
    int unsigned val [5];
    idx = '{mp3_pkg::CFG_PADDED_WIDTH, mp3_pkg::CFG_PADDED_HEIGHT,
            mp3_pkg::CFG_OUT_WIDTH, mp3_pkg::CFG_OUT_HEIGHT,
            mp3_pkg::CFG_STRIDE_TWO};
    val = '{w, h, ow, oh, s};
    for (int i = 0; i < 5; i++) begin
      cfg_write_en <= 1'b1;
      cfg_index    <= idx[i];
      cfg_data     <= val[i][15:0];
      @(posedge clk);
    end
    cfg_write_en <= 1'b0;
    reg_width  = w & 16'h7FF;
    reg_height = h & 16'hFFFF;
    reg_out_w  = ow & 16'h3FF;
    reg_out_h  = oh & 16'hFFFF;
    reg_stride = s & 1;
  endtask

  // Lane values lean on the fp32 special patterns.
  function automatic logic [31:0] rand_lane();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 9))
      0: return {v[31], 8'hFF, v[22], v[21:0] | 22'd1};
      1: return {v[31], 31'd0};
      2: return {v[31], 8'hFF, 23'd0};
      3: return {v[31], v[30:16], 16'd0};
      default: return v;
    endcase
  endfunction

  function automatic pixel_t rand_pixel();
    pixel_t p;
    for (int k = 0; k < mp3_pkg::LANES; k++) p[k] = rand_lane();
    return p;
  endfunction

  // Results are accepted at the rising edge that follows a falling edge where
  // out_valid is high and out_stall is low.
  always @(negedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_max.size() == 0) begin
        $error("unexpected result: lane0_max=%h", out_m0);
        errors++;
      end else begin
        pool_result_t e;
        e = pending_max.pop_front();
        if (out_m0 !== e.window_max[0]) begin
          $error("lane0_max expected %h actual %h", e.window_max[0], out_m0); errors++;
        end
        if (out_m1 !== e.window_max[1]) begin
          $error("lane1_max expected %h actual %h", e.window_max[1], out_m1); errors++;
        end
        if (out_m2 !== e.window_max[2]) begin
          $error("lane2_max expected %h actual %h", e.window_max[2], out_m2); errors++;
        end
        if (out_m3 !== e.window_max[3]) begin
          $error("lane3_max expected %h actual %h", e.window_max[3], out_m3); errors++;
        end
        if (out_image_done !== e.last) begin
          $error("image_done expected %b actual %b", e.last, out_image_done); errors++;
        end
      end
    end
  end

  // Receiver stalls in short random bursts.
  int stall_left;
  always @(posedge clk) begin
    if (!rst_n || quiet) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin
    #3_000_000;
    $display("testbench failed");
    $finish;
  end

  directed_row_t dir_rows [$];

  initial begin
    directed_row_t row;
    int unsigned w, h, ow, oh, s, n_img, weff, heff;
    bit paused_once;
    errors = 0;
    pixels_sent = 0;
    quiet = 1'b0;
    paused_once = 1'b0;
    rst_n = 1'b0;
    cfg_write_en = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_px = '0;
    for (int i = 0; i < 1024; i++) begin
      upper_rows[i] = '0;
      middle_rows[i] = '0;
    end
    col_hist[0] = '0;
    col_hist[1] = '0;
    row_pos = 0; col_pos = 0;
    reg_width = 3; reg_height = 3; reg_out_w = 1; reg_out_h = 1; reg_stride = 0;

    // Two 3x3 images at the reset setting. Lane 0: NaNs lose to one number.
    // Lane 1: all NaNs give the canonical NaN. Lane 2: -0 against +0.
    // Lane 3: infinities and the largest patterns.
    for (int i = 0; i < 9; i++) begin
      row.px[0] = (i == 4) ? 32'h3F80_0000 : 32'h7FC0_0001 | (i << 4);
      row.px[1] = (i[0]) ? 32'hFFFF_FFFF : 32'h7F80_0001;
      row.px[2] = (i == 8) ? 32'h8000_0000 : (i == 3 ? 32'h0000_0000 : 32'h8000_0000);
      row.px[3] = (i == 7) ? 32'h7F80_0000 : (i == 2 ? 32'hFF80_0000 : 32'h7F7F_FFFF);
      row.typed = (i == 8);
      row.want = {32'h7F80_0000, 32'h0000_0000, mp3_pkg::CANON_NAN, 32'h3F80_0000};
      row.want_last = 1'b1;
      dir_rows.push_back(row);
    end
    // Second image: negatives and NaNs, zero against the smallest subnormal.
    for (int i = 0; i < 9; i++) begin
      row.px[0] = 32'hBF80_0000 + i;
      row.px[1] = (i == 5) ? 32'h0000_0001 : 32'h8000_0000;
      row.px[2] = (i == 0) ? 32'h0000_0000 : 32'hFF80_0000;
      row.px[3] = (i == 6) ? 32'h8000_0001 : 32'hFFFF_FFFF;
      row.typed = (i == 8);
      row.want = {32'h8000_0001, 32'h0000_0000, 32'h0000_0001, 32'hBF80_0000};
      row.want_last = 1'b1;
      dir_rows.push_back(row);
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i])
      send_pixel(dir_rows[i].px, dir_rows[i].typed, dir_rows[i].want, dir_rows[i].want_last);
    wait_drained();

    // Wide image, output width and height beyond what fits.
    set_config(300, 3, 1022, 65535, 0);
    for (int i = 0; i < 300 * 3; i++) send_pixel(rand_pixel());
    wait_drained();

    // Tallest image, left after five rows; the next size puts row 0 back.
    set_config(3, 65535, 1023, 65535, 1);
    for (int i = 0; i < 15; i++) send_pixel(rand_pixel());
    wait_drained();

    // Clamped small sizes, then a zero output size.
    set_config(0, 0, 5, 5, 1);
    for (int i = 0; i < 18; i++) send_pixel(rand_pixel());
    wait_drained();
    set_config(7, 6, 0, 4, 0);
    for (int i = 0; i < 42; i++) send_pixel(rand_pixel());
    wait_drained();

    // Random phases of whole images.
    while (pixels_sent < 1400) begin
      w = $urandom_range(0, 7) == 0 ? $urandom_range(0, 2) : $urandom_range(3, 12);
      h = $urandom_range(0, 10);
      ow = $urandom_range(0, 12);
      oh = $urandom_range(0, 10);
      s = $urandom_range(0, 1);
      n_img = $urandom_range(1, 3);
      weff = w < 3 ? 3 : w;
      heff = h < 3 ? 3 : h;
      set_config(w, h, ow, oh, s);
      for (int i = 0; i < n_img * weff * heff; i++) begin
        if (!paused_once && pixels_sent > 1100 && i > 5) begin
          paused_once = 1'b1;
          in_valid <= 1'b0;
          @(posedge clk);
          while (pending_max.size() != 0) @(posedge clk);
        end
        if (pixels_sent > 1250) quiet = 1'b1;
        send_pixel(rand_pixel());
      end
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (pending_max.size() != 0) begin
      $error("%0d expected results never arrived", pending_max.size());
      errors++;
    end
    if (errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

/* max_pool_3x3_stream.f */
hw/rtl/mp3_pkg.sv
hw/rtl/mp3_ram.sv
hw/rtl/mp3_ctrl.sv
hw/rtl/mp3_lane.sv
hw/rtl/max_pool_3x3_stream.sv
dv/testbench.sv
